// ----- hw/rtl/rrws_pkg.sv -----
// Shared types and codes for the round-robin ready/wait scheduler.
// Used by the cell, the cell row and the top level; depends on nothing.
package rrws_pkg;

	localparam int unsigned ID_W = 8;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_YIELD = 3'd1,
		OP_BLOCK = 3'd2,
		OP_EXIT  = 3'd3,
		OP_ADMIT = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_RUNNING  = 3'd0,
		ST_BLOCKED  = 3'd1,
		ST_FINISHED = 3'd2,
		ST_INVALID  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROMOTE,
		S_PLAN,
		S_ROTATE,
		S_FINISH
	} state_t;

	// Control for one row of cells: shift toward the head, and/or write one entry.
	typedef struct packed {
		logic            shift;
		logic            wr_en;
		logic [ID_W-1:0] wr_data;
	} ctl_t;

endpackage

// ----- hw/rtl/round_robin_ready_wait_scheduler_unit.sv -----
// Round-robin thread scheduler: yield, block, exit, start and admit requests over a ready
// row and a waiting row of thread-id cells. Yield, block and exit walk the waiting row,
// then turn the ready row around; start and admit turn the ready row only, and an invalid
// or refused request goes straight to the result. A new request is taken only once the
// previous one has loaded its result.
// Reset clears the lengths, the slot and the control; the rows hold nothing until written.
module round_robin_ready_wait_scheduler_unit #(
	parameter int unsigned MAX_THREADS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  thread_id,
	input  logic [15:0] ready_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  running_id,
	output logic [2:0]  status,
	output logic [4:0]  ready_count,
	output logic [4:0]  waiting_count
);

	// IW indexes a cell, CW holds a count up to MAX_THREADS itself.
	localparam int unsigned IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int unsigned CW = $clog2(MAX_THREADS + 1);
	localparam int unsigned SW = CW + 1;

	// Control state.
	rrws_pkg::state_t state_q, state_d;
	logic             out_valid_q, out_valid_d;
	logic [CW-1:0]    rl_q, rl_d;       // ready length
	logic [CW-1:0]    wl_q, wl_d;       // waiting length
	logic [IW-1:0]    slot_q, slot_d;   // current slot

	// Per-request working registers.
	logic [2:0]             op_q, op_d;
	logic [15:0]            mask_q, mask_d;
	logic [CW-1:0]          rem_q, rem_d;
	logic [IW-1:0]          j_q, j_d;
	logic [IW-1:0]          orig_q, orig_d;
	logic [CW-1:0]          plen_q, plen_d;
	logic [7:0]             last_q, last_d;
	logic [7:0]             fill_q, fill_d;
	logic [7:0]             run_q, run_d;
	rrws_pkg::status_t      st_q, st_d;

	// Output register.
	logic [7:0]             out_run_q, out_run_d;
	rrws_pkg::status_t      out_st_q, out_st_d;
	logic [4:0]             out_rc_q, out_rc_d;
	logic [4:0]             out_wc_q, out_wc_d;

	// Row control.
	rrws_pkg::ctl_t         rctl, wctl;
	logic [IW-1:0]          rpos, wpos;
	logic [7:0]             rhead, whead;

	rrws_chain #(.DEPTH(MAX_THREADS), .IW(IW)) u_ready (
		.clk  (clk),
		.ctl  (rctl),
		.pos  (rpos),
		.head (rhead)
	);

	rrws_chain #(.DEPTH(MAX_THREADS), .IW(IW)) u_waiting (
		.clk  (clk),
		.ctl  (wctl),
		.pos  (wpos),
		.head (whead)
	);

	// The sequencer. A request runs through these phases:
	//   IDLE    - take the request; admit writes its id at the ready tail right here.
	//   PROMOTE - walk the waiting row one entry a cycle. The head leaves; a flagged one is
	//             appended to the ready tail, any other goes back to the waiting tail, so
	//             after waiting_len steps the kept entries sit in order at the front.
	//   PLAN    - work out the slot that will run and set up the ready-row pass.
	//   ROTATE  - turn the ready row once around. The id that block/exit removes is
	//             replaced by the last entry (kept in last_q) and the old last one is
	//             dropped at the end of the turn. The id that lands in the run slot is
	//             captured on the way.
	//   FINISH  - form the status and load the output register once it is free.
	always_comb begin
		logic          take;
		logic          last_step;
		logic          at_end;
		logic          do_push;
		logic          do_drop;
		logic [7:0]    push_val;
		logic [IW-1:0] slot_norm;
		logic [31:0]   rc_ext;
		logic [31:0]   wc_ext;

		state_d     = state_q;
		out_valid_d = out_valid_q;
		rl_d        = rl_q;
		wl_d        = wl_q;
		slot_d      = slot_q;
		op_d        = op_q;
		mask_d      = mask_q;
		rem_d       = rem_q;
		j_d         = j_q;
		orig_d      = orig_q;
		plen_d      = plen_q;
		last_d      = last_q;
		fill_d      = fill_q;
		run_d       = run_q;
		st_d        = st_q;
		out_run_d   = out_run_q;
		out_st_d    = out_st_q;
		out_rc_d    = out_rc_q;
		out_wc_d    = out_wc_q;

		rctl      = '{shift: 1'b0, wr_en: 1'b0, wr_data: '0};
		wctl      = '{shift: 1'b0, wr_en: 1'b0, wr_data: '0};
		rpos      = '0;
		wpos      = '0;

		take      = (op_q == rrws_pkg::OP_BLOCK) || (op_q == rrws_pkg::OP_EXIT);
		last_step = (CW'(j_q) == (plen_q - CW'(1)));
		at_end    = (CW'(slot_q) == (rl_q - CW'(1)));
		do_push   = 1'b0;
		do_drop   = 1'b0;
		push_val  = rhead;
		slot_norm = (CW'(slot_q) >= rl_q) ? '0 : slot_q;
		rc_ext    = 32'(rl_q);
		wc_ext    = 32'(wl_q);

		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			rrws_pkg::S_IDLE: begin
				if (in_valid) begin
					op_d   = op;
					mask_d = ready_mask;
					rem_d  = wl_q;
					st_d   = rrws_pkg::ST_RUNNING;
					slot_d = slot_norm;
					unique case (op)
						rrws_pkg::OP_START: begin
							slot_d  = '0;
							state_d = rrws_pkg::S_PLAN;
						end
						rrws_pkg::OP_YIELD, rrws_pkg::OP_BLOCK, rrws_pkg::OP_EXIT: begin
							state_d = rrws_pkg::S_PROMOTE;
						end
						rrws_pkg::OP_ADMIT: begin
							if ((SW'(rl_q) + SW'(wl_q)) >= SW'(MAX_THREADS) ||
							    rl_q >= CW'(MAX_THREADS)) begin
								st_d    = rrws_pkg::ST_FULL;
								state_d = rrws_pkg::S_FINISH;
							end else begin
								rctl.wr_en   = 1'b1;
								rctl.wr_data = thread_id;
								rpos         = IW'(rl_q);
								rl_d         = rl_q + CW'(1);
								last_d       = thread_id;
								state_d      = rrws_pkg::S_PLAN;
							end
						end
						default: begin
							st_d    = rrws_pkg::ST_INVALID;
							state_d = rrws_pkg::S_FINISH;
						end
					endcase
				end
			end

			rrws_pkg::S_PROMOTE: begin
				if (rem_q == '0) begin
					state_d = rrws_pkg::S_PLAN;
				end else begin
					wctl.shift = 1'b1;
					if (mask_q[0]) begin
						wl_d         = wl_q - CW'(1);
						rctl.wr_en   = 1'b1;
						rctl.wr_data = whead;
						rpos         = IW'(rl_q);
						rl_d         = rl_q + CW'(1);
						last_d       = whead;
					end else begin
						wctl.wr_en   = 1'b1;
						wctl.wr_data = whead;
						wpos         = IW'(wl_q - CW'(1));
					end
					mask_d = mask_q >> 1;
					rem_d  = rem_q - CW'(1);
				end
			end

			rrws_pkg::S_PLAN: begin
				if (rl_q == '0) begin
					state_d = rrws_pkg::S_FINISH;
				end else begin
					plen_d = rl_q;
					fill_d = last_q;
					j_d    = '0;
					orig_d = slot_q;
					if (op_q == rrws_pkg::OP_YIELD) begin
						slot_d = at_end ? '0 : (slot_q + IW'(1));
					end else if (take) begin
						slot_d = at_end ? '0 : slot_q;
					end
					state_d = rrws_pkg::S_ROTATE;
				end
			end

			rrws_pkg::S_ROTATE: begin
				rctl.shift = 1'b1;
				if (take && (j_q == orig_q)) begin
					if (op_q == rrws_pkg::OP_BLOCK) begin
						wctl.wr_en   = 1'b1;
						wctl.wr_data = rhead;
						wpos         = IW'(wl_q);
						wl_d         = wl_q + CW'(1);
					end
					if (last_step) begin
						do_drop = 1'b1;
					end else begin
						do_push  = 1'b1;
						push_val = fill_q;
					end
				end else if (take && last_step) begin
					do_drop = 1'b1;
				end else begin
					do_push = 1'b1;
				end

				if (do_push) begin
					rctl.wr_en   = 1'b1;
					rctl.wr_data = push_val;
					rpos         = IW'(rl_q - CW'(1));
					last_d       = push_val;
					if (j_q == slot_q) begin
						run_d = push_val;
					end
				end
				if (do_drop) begin
					rl_d = rl_q - CW'(1);
				end

				j_d = j_q + IW'(1);
				if (last_step) begin
					state_d = rrws_pkg::S_FINISH;
				end
			end

			rrws_pkg::S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					out_rc_d    = rc_ext[4:0];
					out_wc_d    = wc_ext[4:0];
					out_run_d   = '0;
					out_st_d    = st_q;
					if (st_q == rrws_pkg::ST_RUNNING) begin
						if (rl_q == '0) begin
							slot_d   = '0;
							out_st_d = (wl_q != '0) ? rrws_pkg::ST_BLOCKED
							                        : rrws_pkg::ST_FINISHED;
						end else begin
							out_run_d = run_q;
						end
					end
					state_d = rrws_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = rrws_pkg::S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrws_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lengths, slot and output valid are cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rl_q        <= '0;
			wl_q        <= '0;
			slot_q      <= '0;
		end else begin
			out_valid_q <= out_valid_d;
			rl_q        <= rl_d;
			wl_q        <= wl_d;
			slot_q      <= slot_d;
		end
	end

	// Working and output payload carry no reset.
	always_ff @(posedge clk) begin
		op_q      <= op_d;
		mask_q    <= mask_d;
		rem_q     <= rem_d;
		j_q       <= j_d;
		orig_q    <= orig_d;
		plen_q    <= plen_d;
		last_q    <= last_d;
		fill_q    <= fill_d;
		run_q     <= run_d;
		st_q      <= st_d;
		out_run_q <= out_run_d;
		out_st_q  <= out_st_d;
		out_rc_q  <= out_rc_d;
		out_wc_q  <= out_wc_d;
	end

	// A request is only taken between walks.
	assign in_stall      = (state_q != rrws_pkg::S_IDLE);
	assign out_valid     = out_valid_q;
	assign running_id    = out_run_q;
	assign status        = out_st_q;
	assign ready_count   = out_rc_q;
	assign waiting_count = out_wc_q;

endmodule

// ----- hw/rtl/rrws_cell.sv -----
// One storage cell of a thread-id row: holds, loads its upper neighbor, or takes a write.
// Depends on rrws_pkg for the row control struct.
module rrws_cell (
	input  logic                        clk,
	input  rrws_pkg::ctl_t              ctl,
	input  logic                        sel,
	input  logic [rrws_pkg::ID_W-1:0]   up,
	output logic [rrws_pkg::ID_W-1:0]   q
);

	logic [rrws_pkg::ID_W-1:0] id_q;

	// A write aimed at this cell wins over the shift.
	always_ff @(posedge clk) begin
		if (sel) begin
			id_q <= ctl.wr_data;
		end else if (ctl.shift) begin
			id_q <= up;
		end
	end

	assign q = id_q;

endmodule

// ----- hw/rtl/rrws_chain.sv -----
// Row of thread-id cells with the head at cell 0; each cell decodes its own write position.
// Depends on rrws_pkg and rrws_cell.
module rrws_chain #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW    = 4
) (
	input  logic                        clk,
	input  rrws_pkg::ctl_t              ctl,
	input  logic [IW-1:0]               pos,
	output logic [rrws_pkg::ID_W-1:0]   head
);

	logic [rrws_pkg::ID_W-1:0] cell_q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [rrws_pkg::ID_W-1:0] up;
		logic                      sel;

		if (i < DEPTH - 1) begin : g_mid
			assign up = cell_q[i+1];
		end else begin : g_top
			assign up = cell_q[i];
		end

		assign sel = ctl.wr_en && (pos == IW'(i));

		rrws_cell u_cell (
			.clk (clk),
			.ctl (ctl),
			.sel (sel),
			.up  (up),
			.q   (cell_q[i])
		);
	end

	assign head = cell_q[0];

endmodule

// ----- dv/sched_event_checker.sv -----
// Checker for the round-robin ready/wait scheduler: predicts each result and compares it.
// Depends on rrws_pkg for the op and status codes; watches the request and result channels.
module sched_event_checker import rrws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  thread_id,
	input  logic [15:0] ready_mask,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  running_id,
	input  logic [2:0]  status,
	input  logic [4:0]  ready_count,
	input  logic [4:0]  waiting_count,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 16;

	typedef struct {
		logic [7:0] running_id;
		status_t    status;
		logic [4:0] ready_count;
		logic [4:0] waiting_count;
	} grant_t;

	logic [7:0]  rdy_ids [DEPTH];
	logic [7:0]  wait_ids [DEPTH];
	int unsigned rdy_len;
	int unsigned wait_len;
	int unsigned slot;
	grant_t      grants_due [$];

	initial begin
		fail_count = 0;
		pending = 0;
		rdy_len = 0;
		wait_len = 0;
		slot = 0;
	end

	// Applies one scheduling request to the local lists and returns the result it gives.
	function automatic grant_t apply_sched_event(logic [2:0] code, logic [7:0] tid,
			logic [15:0] mask);
		grant_t      g;
		int unsigned keep;
		logic [7:0]  taken;
		g.running_id = '0;
		g.status = ST_RUNNING;
		if (slot >= rdy_len)
			slot = 0;
		if (code > OP_ADMIT) begin
			g.status = ST_INVALID;
		end else if (code == OP_ADMIT) begin
			if (rdy_len + wait_len >= DEPTH) begin
				g.status = ST_FULL;
			end else begin
				rdy_ids[rdy_len] = tid;
				rdy_len++;
			end
		end else if (code == OP_START) begin
			slot = 0;
		end else begin
			// Flagged waiting entries move to the ready tail in order; the rest close up.
			keep = 0;
			for (int unsigned i = 0; i < wait_len; i++) begin
				if (mask[i] && rdy_len < DEPTH) begin
					rdy_ids[rdy_len] = wait_ids[i];
					rdy_len++;
				end else begin
					wait_ids[keep] = wait_ids[i];
					keep++;
				end
			end
			wait_len = keep;
			if (rdy_len > 0) begin
				if (code == OP_YIELD) begin
					slot = (slot == rdy_len - 1) ? 0 : slot + 1;
				end else begin
					// Block and exit both pull the current thread and patch the hole
					// with the last ready entry.
					taken = rdy_ids[slot];
					rdy_ids[slot] = rdy_ids[rdy_len - 1];
					if (slot == rdy_len - 1)
						slot = 0;
					rdy_len--;
					if (code == OP_BLOCK && wait_len < DEPTH) begin
						wait_ids[wait_len] = taken;
						wait_len++;
					end
				end
			end
		end
		if (g.status == ST_RUNNING) begin
			if (rdy_len == 0) begin
				slot = 0;
				g.status = (wait_len > 0) ? ST_BLOCKED : ST_FINISHED;
			end else begin
				if (slot >= rdy_len)
					slot = 0;
				g.running_id = rdy_ids[slot];
			end
		end
		g.ready_count = rdy_len[4:0];
		g.waiting_count = wait_len[4:0];
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			rdy_len = 0;
			wait_len = 0;
			slot = 0;
			grants_due.delete();
		end else begin
			// A request taken at this edge is older than nothing still queued, so it goes
			// in before a result at the same edge is matched.
			if (in_valid && !in_stall)
				grants_due.push_back(apply_sched_event(op, thread_id, ready_mask));
			if (out_valid && !out_stall) begin
				if (grants_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: id %0d status %0d ready %0d waiting %0d",
						$realtime, running_id, status, ready_count, waiting_count);
				end else begin
					want = grants_due.pop_front();
					if (running_id !== want.running_id || status !== want.status ||
							ready_count !== want.ready_count ||
							waiting_count !== want.waiting_count) begin
						fail_count++;
						$display("%0t: mismatch: expected id %0d status %0d ready %0d waiting %0d, %s",
							$realtime, want.running_id, want.status, want.ready_count,
							want.waiting_count, $sformatf("actual id %0d status %0d ready %0d waiting %0d",
							running_id, status, ready_count, waiting_count));
					end
				end
			end
		end
		pending = grants_due.size();
	end

endmodule

// ----- dv/tb_round_robin_ready_wait_scheduler_unit.sv -----
// Top of the scheduler testbench: clock, reset, request stimulus and the final verdict.
// Depends on rrws_pkg, the scheduler unit and sched_event_checker, which does the checking.
module tb_round_robin_ready_wait_scheduler_unit;
	import rrws_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Number of requests after which the stimulus stops.
	localparam int unsigned REQ_TARGET = 650;
	// Longest walk is both rows full plus the fixed overhead; leave margin on top.
	localparam int unsigned TAIL_CYCLES = 48;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [2:0]  op = OP_START;
	logic [7:0]  thread_id = '0;
	logic [15:0] ready_mask = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [7:0]  running_id;
	logic [2:0]  status;
	logic [4:0]  ready_count;
	logic [4:0]  waiting_count;
	int          fail_count;
	int          pending;

	int unsigned sent = 0;
	int unsigned burst_left = 0;

	round_robin_ready_wait_scheduler_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.thread_id    (thread_id),
		.ready_mask   (ready_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.running_id   (running_id),
		.status       (status),
		.ready_count  (ready_count),
		.waiting_count(waiting_count)
	);

	sched_event_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.thread_id    (thread_id),
		.ready_mask   (ready_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.running_id   (running_id),
		.status       (status),
		.ready_count  (ready_count),
		.waiting_count(waiting_count),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls in phases: none at all, light random stalls, or mostly
	// stalled. Each phase lasts a random number of cycles so that stalls land on every
	// step of the scheduler's walk, and the quiet phases give clean back-to-back stretches.
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(32, 256);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 2) == 0);
			end
			default: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
		endcase
	end

	// Presents one request and holds it until the scheduler takes it. The sender works in
	// bursts: when a burst runs out, valid drops for a random gap before the next request.
	// Valid is only lowered in the step of the previous acceptance and raised in a later
	// step, so it never gets two assignments in one step.
	task automatic send_request(input logic [2:0] code, input logic [7:0] tid,
			input logic [15:0] mask);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		op <= code;
		thread_id <= tid;
		ready_mask <= mask;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Pauses the sender until every outstanding request has produced its result.
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Readiness masks lean toward the interesting shapes: nothing ready, everything
	// ready, a single waiting position, and fully random patterns.
	function automatic logic [15:0] pick_mask();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return '0;
		else if (r < 40)
			return '1;
		else if (r < 55)
			return 16'(1) << $urandom_range(0, 15);
		else
			return 16'($urandom);
	endfunction

	initial begin
		int unsigned kind;
		int unsigned n;
		int unsigned r;
		logic [2:0]  code;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. With nothing admitted, start and yield both report that all
		// threads are finished; a full mask on an empty waiting list must promote nothing.
		send_request(OP_START, 8'($urandom), '0);
		send_request(OP_YIELD, 8'($urandom), '1);
		// Every unused op code is refused and changes nothing.
		for (int c = int'(OP_ADMIT) + 1; c < (1 << $bits(op)); c++)
			send_request(3'(c), 8'($urandom), 16'($urandom));
		// Admit the extreme ids, then yield round the ring until the slot wraps.
		send_request(OP_ADMIT, 8'h00, 16'($urandom));
		send_request(OP_ADMIT, 8'hFF, 16'($urandom));
		send_request(OP_ADMIT, 8'h5A, 16'($urandom));
		repeat (3) send_request(OP_YIELD, 8'($urandom), '0);
		// Two blocks and an exit empty the ready list while threads still wait, so every
		// live thread is blocked; a yield with no mask bits leaves it that way.
		send_request(OP_BLOCK, 8'($urandom), '0);
		send_request(OP_BLOCK, 8'($urandom), '0);
		send_request(OP_EXIT, 8'($urandom), '0);
		send_request(OP_YIELD, 8'($urandom), '0);
		// Admit does not promote the waiting threads; start resets the slot.
		send_request(OP_ADMIT, 8'hA5, '1);
		send_request(OP_START, 8'($urandom), '1);
		// Mask bits at or above the waiting length are ignored.
		send_request(OP_EXIT, 8'($urandom), 16'hFFFC);
		// Promote the second waiting thread only, then block it again.
		send_request(OP_BLOCK, 8'($urandom), 16'h0002);
		send_request(OP_YIELD, 8'($urandom), '1);
		repeat (3) send_request(OP_EXIT, 8'($urandom), '0);
		wait_drained();

		// Random part, in episodes. Fill episodes admit fresh threads and often run into
		// the full limit; churn episodes mix scheduling requests with readiness masks so
		// the lists keep moving; noise episodes throw refused and arbitrary codes in.
		while (sent < REQ_TARGET) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				n = $urandom_range(4, 18);
				repeat (n) send_request(OP_ADMIT, 8'($urandom), 16'($urandom));
			end else if (kind < 9) begin
				n = $urandom_range(5, 30);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 10)
						code = OP_START;
					else if (r < 40)
						code = OP_YIELD;
					else if (r < 60)
						code = OP_BLOCK;
					else if (r < 75)
						code = OP_EXIT;
					else
						code = OP_ADMIT;
					send_request(code, 8'($urandom), pick_mask());
				end
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					if ($urandom_range(0, 1) == 0)
						code = 3'($urandom_range(int'(OP_ADMIT) + 1, (1 << $bits(op)) - 1));
					else
						code = 3'($urandom);
					send_request(code, 8'($urandom), 16'($urandom));
				end
			end
			// Now and then let the scheduler go fully idle before carrying on.
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
